FILE: design/node_to_face_adjacency_builder_defines.svh
// Assertion macros used by the adjacency builder datapath (ntf_dp).
`ifndef NODE_TO_FACE_ADJACENCY_BUILDER_DEFINES_SVH
`define NODE_TO_FACE_ADJACENCY_BUILDER_DEFINES_SVH

// Property checked every cycle outside reset.
`define NTF_CHECK(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error("ntf check failed");

// Same-cycle implication outside reset.
`define NTF_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("ntf implication failed");

// Next-cycle implication outside reset.
`define NTF_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("ntf sequence failed");

`endif

FILE: design/ntf_pkg.sv
package ntf_pkg;

    localparam int MAX_NODES      = 1024;
    localparam int MAX_FACES      = 1024;
    localparam int MAX_FACE_NODES = 4;
    localparam int MAX_ENTRIES    = 4096;

    localparam int NODE_W  = 10;   // node index
    localparam int FACE_W  = 10;   // face index
    localparam int FCNT_W  = 11;   // face count, holds MAX_FACES
    localparam int SIZE_W  = 3;    // face size
    localparam int ENT_W   = 12;   // entry table address
    localparam int CNT_W   = 13;   // valence / corner count, holds MAX_ENTRIES
    localparam int CFG_W   = 11;
    localparam int SLOT_W  = 12;
    localparam int FWORD_W = SIZE_W + MAX_FACE_NODES * NODE_W;

    localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(1024);

    // item kinds
    localparam logic [1:0] KIND_ADD   = 2'd0;
    localparam logic [1:0] KIND_BUILD = 2'd1;
    localparam logic [1:0] KIND_QUERY = 2'd2;
    localparam logic [1:0] KIND_CLEAR = 2'd3;

    // result status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_RANGE     = 2'd1;
    localparam logic [1:0] ST_NOT_BUILT = 2'd2;
    localparam logic [1:0] ST_SLOT      = 2'd3;

    // datapath operations
    typedef enum logic [4:0] {
        OP_NONE,
        OP_CAP,
        OP_CLR,
        OP_ADD_CHK,
        OP_ADD_RD,
        OP_ADD_WR,
        OP_PFX_RD,
        OP_PFX_WR,
        OP_FACE_RD,
        OP_FACE_NX,
        OP_COR_RD,
        OP_COR_WR,
        OP_BLT,
        OP_Q_RD,
        OP_Q_BK,
        OP_Q_FIN,
        OP_OUT
    } t_op;

    typedef struct packed {
        t_op  op;
        logic idle;
    } t_cmd;

    typedef struct packed {
        logic [1:0] kind;
        logic       add_bad;
        logic       cor_done;
        logic       face_done;
        logic       idx_last;
        logic       out_free;
    } t_sts;

endpackage

FILE: design/ntf_ctrl.sv
module ntf_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  ntf_pkg::t_sts i_sts,
    output ntf_pkg::t_cmd o_cmd
);

    typedef enum logic [14:0] {
        S_INIT     = 15'b000000000000001,
        S_IDLE     = 15'b000000000000010,
        S_ADD_CHK  = 15'b000000000000100,
        S_ADD_RD   = 15'b000000000001000,
        S_ADD_WR   = 15'b000000000010000,
        S_PFX_RD   = 15'b000000000100000,
        S_PFX_WR   = 15'b000000001000000,
        S_FACE_CHK = 15'b000000010000000,
        S_COR_RD   = 15'b000000100000000,
        S_COR_WR   = 15'b000001000000000,
        S_Q_RD     = 15'b000010000000000,
        S_Q_BK     = 15'b000100000000000,
        S_Q_FIN    = 15'b001000000000000,
        S_CLR      = 15'b010000000000000,
        S_RES      = 15'b100000000000000
    } t_state;

    t_state     r_state;
    t_state     n_state;
    ntf_pkg::t_op w_op;

    // next state and datapath command
    always_comb begin
        n_state = r_state;
        w_op    = ntf_pkg::OP_NONE;
        case (r_state)
            S_INIT: begin
                w_op = ntf_pkg::OP_CLR;
                if (i_sts.idx_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_valid) begin
                    w_op = ntf_pkg::OP_CAP;
                    case (i_sts.kind)
                        ntf_pkg::KIND_ADD:   n_state = S_ADD_CHK;
                        ntf_pkg::KIND_BUILD: n_state = S_PFX_RD;
                        ntf_pkg::KIND_QUERY: n_state = S_Q_RD;
                        default:             n_state = S_CLR;
                    endcase
                end
            end
            S_ADD_CHK: begin
                w_op    = ntf_pkg::OP_ADD_CHK;
                n_state = i_sts.add_bad ? S_RES : S_ADD_RD;
            end
            S_ADD_RD: begin
                if (i_sts.cor_done) begin
                    n_state = S_RES;
                end else begin
                    w_op    = ntf_pkg::OP_ADD_RD;
                    n_state = S_ADD_WR;
                end
            end
            S_ADD_WR: begin
                w_op    = ntf_pkg::OP_ADD_WR;
                n_state = S_ADD_RD;
            end
            S_PFX_RD: begin
                w_op    = ntf_pkg::OP_PFX_RD;
                n_state = S_PFX_WR;
            end
            S_PFX_WR: begin
                w_op    = ntf_pkg::OP_PFX_WR;
                n_state = i_sts.idx_last ? S_FACE_CHK : S_PFX_RD;
            end
            S_FACE_CHK: begin
                if (i_sts.face_done) begin
                    w_op    = ntf_pkg::OP_BLT;
                    n_state = S_RES;
                end else begin
                    w_op    = ntf_pkg::OP_FACE_RD;
                    n_state = S_COR_RD;
                end
            end
            S_COR_RD: begin
                if (i_sts.cor_done) begin
                    w_op    = ntf_pkg::OP_FACE_NX;
                    n_state = S_FACE_CHK;
                end else begin
                    w_op    = ntf_pkg::OP_COR_RD;
                    n_state = S_COR_WR;
                end
            end
            S_COR_WR: begin
                w_op    = ntf_pkg::OP_COR_WR;
                n_state = S_COR_RD;
            end
            S_Q_RD: begin
                w_op    = ntf_pkg::OP_Q_RD;
                n_state = S_Q_BK;
            end
            S_Q_BK: begin
                w_op    = ntf_pkg::OP_Q_BK;
                n_state = S_Q_FIN;
            end
            S_Q_FIN: begin
                w_op    = ntf_pkg::OP_Q_FIN;
                n_state = S_RES;
            end
            S_CLR: begin
                w_op = ntf_pkg::OP_CLR;
                if (i_sts.idx_last) n_state = S_RES;
            end
            S_RES: begin
                if (i_sts.out_free) begin
                    w_op    = ntf_pkg::OP_OUT;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_INIT;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_INIT;
        else          r_state <= n_state;
    end

    assign o_cmd.op   = w_op;
    assign o_cmd.idle = (r_state == S_IDLE);

endmodule

FILE: design/ntf_dp.sv
`include "node_to_face_adjacency_builder_defines.svh"

module ntf_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  ntf_pkg::t_cmd                 i_cmd,
    output ntf_pkg::t_sts                 o_sts,
    input  logic [1:0]                    i_kind,
    input  logic [ntf_pkg::SIZE_W-1:0]    i_face_size,
    input  logic [ntf_pkg::NODE_W-1:0]    i_node_a,
    input  logic [ntf_pkg::NODE_W-1:0]    i_node_b,
    input  logic [ntf_pkg::NODE_W-1:0]    i_node_c,
    input  logic [ntf_pkg::NODE_W-1:0]    i_node_d,
    input  logic [ntf_pkg::NODE_W-1:0]    i_query_node,
    input  logic [ntf_pkg::SLOT_W-1:0]    i_query_slot,
    input  logic                          i_cfg_valid,
    input  logic [ntf_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic                          i_stall,
    output logic                          o_valid,
    output logic [1:0]                    o_status,
    output logic [ntf_pkg::CNT_W-1:0]     o_valence,
    output logic [ntf_pkg::ENT_W-1:0]     o_bucket_start,
    output logic [ntf_pkg::FACE_W-1:0]    o_face_index
);

    localparam int NW = ntf_pkg::NODE_W;

    // memories
    logic [ntf_pkg::FWORD_W-1:0] m_face [ntf_pkg::MAX_FACES];
    logic [ntf_pkg::CNT_W-1:0]   m_val  [ntf_pkg::MAX_NODES];
    logic [ntf_pkg::ENT_W-1:0]   m_off  [ntf_pkg::MAX_NODES];
    logic [ntf_pkg::CNT_W-1:0]   m_fill [ntf_pkg::MAX_NODES];
    logic [ntf_pkg::FACE_W-1:0]  m_bkt  [ntf_pkg::MAX_ENTRIES];

    // captured item
    logic [1:0]                  r_kind;
    logic [ntf_pkg::SIZE_W-1:0]  r_size;
    logic [NW-1:0]               r_node [ntf_pkg::MAX_FACE_NODES];
    logic [NW-1:0]               r_qn;
    logic [ntf_pkg::SLOT_W-1:0]  r_qs;

    // control state
    logic [ntf_pkg::CFG_W-1:0]   r_cfg;
    logic [ntf_pkg::FCNT_W-1:0]  r_faces;
    logic [ntf_pkg::CNT_W-1:0]   r_corner;
    logic                        r_built;
    logic [NW-1:0]               r_idx;
    logic [ntf_pkg::CNT_W-1:0]   r_acc;
    logic [ntf_pkg::FCNT_W-1:0]  r_fi;
    logic [ntf_pkg::SIZE_W-1:0]  r_j;
    logic                        r_ovalid;

    // registered read data
    logic [ntf_pkg::FWORD_W-1:0] r_face_rd;
    logic [ntf_pkg::CNT_W-1:0]   r_val_rd;
    logic [ntf_pkg::ENT_W-1:0]   r_off_rd;
    logic [ntf_pkg::CNT_W-1:0]   r_fill_rd;
    logic [ntf_pkg::FACE_W-1:0]  r_bkt_rd;

    // pending result
    logic [1:0]                  r_rs_status;
    logic [ntf_pkg::CNT_W-1:0]   r_rs_val;
    logic [ntf_pkg::ENT_W-1:0]   r_rs_start;
    logic [ntf_pkg::FACE_W-1:0]  r_rs_face;

    ntf_pkg::t_op                w_op;
    logic [NW-1:0]               w_add_node;
    logic [NW-1:0]               w_face_node;
    logic [ntf_pkg::SIZE_W-1:0]  w_size_sel;
    logic                        w_node_bad;
    logic                        w_add_bad;
    logic [ntf_pkg::CNT_W-1:0]   w_pos;
    logic                        w_out_free;

    assign w_op        = i_cmd.op;
    assign w_add_node  = r_node[r_j[1:0]];
    assign w_face_node = r_face_rd[r_j[1:0]*NW +: NW];
    assign w_size_sel  = (r_kind == ntf_pkg::KIND_BUILD) ?
                         r_face_rd[ntf_pkg::FWORD_W-1 -: ntf_pkg::SIZE_W] : r_size;
    assign w_pos       = {1'b0, r_off_rd} + {1'b0, r_qs};
    assign w_out_free  = !r_ovalid || !i_stall;

    // add-face acceptance check
    always_comb begin
        w_node_bad = 1'b0;
        for (int k = 0; k < ntf_pkg::MAX_FACE_NODES; k++) begin
            if ((ntf_pkg::SIZE_W'(k) < r_size) && ({1'b0, r_node[k]} >= r_cfg))
                w_node_bad = 1'b1;
        end
    end
    assign w_add_bad = r_faces[ntf_pkg::FCNT_W-1]
                    || (r_size > ntf_pkg::SIZE_W'(ntf_pkg::MAX_FACE_NODES))
                    || ((r_corner + ntf_pkg::CNT_W'(r_size))
                        > ntf_pkg::CNT_W'(ntf_pkg::MAX_ENTRIES))
                    || w_node_bad;

    assign o_sts.kind      = (w_op == ntf_pkg::OP_NONE) ? i_kind : i_kind;
    assign o_sts.add_bad   = w_add_bad;
    assign o_sts.cor_done  = (r_j >= w_size_sel);
    assign o_sts.face_done = (r_fi >= r_faces);
    assign o_sts.idx_last  = (r_idx == NW'(ntf_pkg::MAX_NODES - 1));
    assign o_sts.out_free  = w_out_free;

    // face store
    always_ff @(posedge i_clk) begin
        if (w_op == ntf_pkg::OP_ADD_CHK && !w_add_bad)
            m_face[r_faces[NW-1:0]] <= {r_size, r_node[3], r_node[2], r_node[1], r_node[0]};
        if (w_op == ntf_pkg::OP_FACE_RD)
            r_face_rd <= m_face[r_fi[NW-1:0]];
    end

    // valence memory: clear sweep, corner count, prefix and query reads
    always_ff @(posedge i_clk) begin
        if (w_op == ntf_pkg::OP_CLR)
            m_val[r_idx] <= '0;
        else if (w_op == ntf_pkg::OP_ADD_WR)
            m_val[w_add_node] <= r_val_rd + ntf_pkg::CNT_W'(1);
        if (w_op == ntf_pkg::OP_ADD_RD)
            r_val_rd <= m_val[w_add_node];
        else if (w_op == ntf_pkg::OP_PFX_RD)
            r_val_rd <= m_val[r_idx];
        else if (w_op == ntf_pkg::OP_Q_RD)
            r_val_rd <= m_val[r_qn];
    end

    // bucket offsets
    always_ff @(posedge i_clk) begin
        if (w_op == ntf_pkg::OP_PFX_WR)
            m_off[r_idx] <= r_acc[ntf_pkg::ENT_W-1:0];
        if (w_op == ntf_pkg::OP_Q_RD)
            r_off_rd <= m_off[r_qn];
    end

    // per-node fill pointers for the scatter pass
    always_ff @(posedge i_clk) begin
        if (w_op == ntf_pkg::OP_PFX_WR)
            m_fill[r_idx] <= r_acc;
        else if (w_op == ntf_pkg::OP_COR_WR)
            m_fill[w_face_node] <= r_fill_rd + ntf_pkg::CNT_W'(1);
        if (w_op == ntf_pkg::OP_COR_RD)
            r_fill_rd <= m_fill[w_face_node];
    end

    // entry table
    always_ff @(posedge i_clk) begin
        if (w_op == ntf_pkg::OP_COR_WR && !r_fill_rd[ntf_pkg::CNT_W-1])
            m_bkt[r_fill_rd[ntf_pkg::ENT_W-1:0]] <= r_fi[ntf_pkg::FACE_W-1:0];
        if (w_op == ntf_pkg::OP_Q_BK)
            r_bkt_rd <= m_bkt[w_pos[ntf_pkg::ENT_W-1:0]];
    end

    // item capture (payload, no reset)
    always_ff @(posedge i_clk) begin
        if (w_op == ntf_pkg::OP_CAP) begin
            r_kind    <= i_kind;
            r_size    <= i_face_size;
            r_node[0] <= i_node_a;
            r_node[1] <= i_node_b;
            r_node[2] <= i_node_c;
            r_node[3] <= i_node_d;
            r_qn      <= i_query_node;
            r_qs      <= i_query_slot;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg    <= ntf_pkg::CFG_RESET;
            r_faces  <= '0;
            r_corner <= '0;
            r_built  <= 1'b0;
            r_idx    <= '0;
            r_acc    <= '0;
            r_fi     <= '0;
            r_j      <= '0;
        end else begin
            if (i_cfg_valid) r_cfg <= i_cfg_data;
            case (w_op)
                ntf_pkg::OP_CAP: begin
                    r_idx <= '0;
                    r_acc <= '0;
                    r_fi  <= '0;
                    r_j   <= '0;
                    if (i_kind == ntf_pkg::KIND_CLEAR) begin
                        r_faces  <= '0;
                        r_corner <= '0;
                        r_built  <= 1'b0;
                    end
                end
                ntf_pkg::OP_CLR: r_idx <= r_idx + NW'(1);
                ntf_pkg::OP_ADD_CHK: begin
                    if (!w_add_bad) begin
                        r_faces  <= r_faces + ntf_pkg::FCNT_W'(1);
                        r_corner <= r_corner + ntf_pkg::CNT_W'(r_size);
                        r_built  <= 1'b0;
                    end
                end
                ntf_pkg::OP_ADD_WR: r_j <= r_j + ntf_pkg::SIZE_W'(1);
                ntf_pkg::OP_PFX_WR: begin
                    r_acc <= r_acc + r_val_rd;
                    r_idx <= r_idx + NW'(1);
                end
                ntf_pkg::OP_FACE_RD: r_j  <= '0;
                ntf_pkg::OP_FACE_NX: r_fi <= r_fi + ntf_pkg::FCNT_W'(1);
                ntf_pkg::OP_COR_WR:  r_j  <= r_j + ntf_pkg::SIZE_W'(1);
                ntf_pkg::OP_BLT:     r_built <= 1'b1;
                default: ;
            endcase
        end
    end

    // result fields
    always_ff @(posedge i_clk) begin
        case (w_op)
            ntf_pkg::OP_CAP: begin
                r_rs_status <= ntf_pkg::ST_OK;
                r_rs_val    <= '0;
                r_rs_start  <= '0;
                r_rs_face   <= '0;
            end
            ntf_pkg::OP_ADD_CHK: r_rs_status <= w_add_bad ? ntf_pkg::ST_RANGE : ntf_pkg::ST_OK;
            ntf_pkg::OP_Q_BK: begin
                if ({1'b0, r_qn} >= r_cfg) begin
                    r_rs_status <= ntf_pkg::ST_RANGE;
                end else if (!r_built) begin
                    r_rs_status <= ntf_pkg::ST_NOT_BUILT;
                    r_rs_val    <= r_val_rd;
                end else begin
                    r_rs_val   <= r_val_rd;
                    r_rs_start <= r_off_rd;
                    if ({1'b0, r_qs} >= r_val_rd) r_rs_status <= ntf_pkg::ST_SLOT;
                    else                          r_rs_status <= ntf_pkg::ST_OK;
                end
            end
            ntf_pkg::OP_Q_FIN: begin
                if (r_rs_status == ntf_pkg::ST_OK && r_kind == ntf_pkg::KIND_QUERY
                    && !w_pos[ntf_pkg::CNT_W-1])
                    r_rs_face <= r_bkt_rd;
            end
            default: ;
        endcase
    end

    // output word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (w_op == ntf_pkg::OP_OUT) begin
            r_ovalid <= 1'b1;
        end else if (!i_stall) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_op == ntf_pkg::OP_OUT) begin
            o_status       <= r_rs_status;
            o_valence      <= r_rs_val;
            o_bucket_start <= r_rs_start;
            o_face_index   <= r_rs_face;
        end
    end

    assign o_valid = r_ovalid;

    `NTF_IMPLY(a_no_overwrite, w_op == ntf_pkg::OP_OUT, w_out_free)
    `NTF_CHECK(a_corner_cap, r_corner <= ntf_pkg::CNT_W'(ntf_pkg::MAX_ENTRIES))
    `NTF_CHECK(a_face_cap, r_faces <= ntf_pkg::FCNT_W'(ntf_pkg::MAX_FACES))
    `NTF_NEXT(a_add_unbuilds, w_op == ntf_pkg::OP_ADD_CHK && !w_add_bad, !r_built)

endmodule

FILE: design/node_to_face_adjacency_builder.sv
// Node-to-face incidence table builder (compressed sparse row layout).
// Input channel: i_valid / o_stall carries one item word (kind, face fields,
// query fields); it is taken when i_valid is high and o_stall is low.
// Output channel: o_valid / i_stall carries exactly one result word per item.
// Config channel: i_cfg_valid / o_cfg_ready writes nodes_in_use; always ready,
// write only while the block is idle.
// Steps per item, from input accept to result in the output register:
//   add face  check, then a valence read-modify-write per corner (check only
//   when rejected); query  valence and offset read, bucket read, finish;
//   clear  valence sweep; build  prefix sweep, then a fill update per corner.
// Items are worked one at a time by a controller over single-port memories.
// A finished word sits in the output register, so the next item is taken
// while the receiver stalls; the block waits only if a second word is ready
// before the first is taken.
// Reset (synchronous, active low) runs a pass zeroing the whole valence
// memory; o_stall stays high until it ends.
module node_to_face_adjacency_builder (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic [1:0]                 i_kind,
    input  logic [ntf_pkg::SIZE_W-1:0] i_face_size,
    input  logic [ntf_pkg::NODE_W-1:0] i_node_a,
    input  logic [ntf_pkg::NODE_W-1:0] i_node_b,
    input  logic [ntf_pkg::NODE_W-1:0] i_node_c,
    input  logic [ntf_pkg::NODE_W-1:0] i_node_d,
    input  logic [ntf_pkg::NODE_W-1:0] i_query_node,
    input  logic [ntf_pkg::SLOT_W-1:0] i_query_slot,
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic [1:0]                 o_status,
    output logic [ntf_pkg::CNT_W-1:0]  o_valence,
    output logic [ntf_pkg::ENT_W-1:0]  o_bucket_start,
    output logic [ntf_pkg::FACE_W-1:0] o_face_index,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [ntf_pkg::CFG_W-1:0]  i_cfg_data
);

    ntf_pkg::t_cmd w_cmd;
    ntf_pkg::t_sts w_sts;

    // sequencer
    ntf_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd)
    );

    // memories, counters and result registers
    ntf_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_sts          (w_sts),
        .i_kind         (i_kind),
        .i_face_size    (i_face_size),
        .i_node_a       (i_node_a),
        .i_node_b       (i_node_b),
        .i_node_c       (i_node_c),
        .i_node_d       (i_node_d),
        .i_query_node   (i_query_node),
        .i_query_slot   (i_query_slot),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_data     (i_cfg_data),
        .i_stall        (i_stall),
        .o_valid        (o_valid),
        .o_status       (o_status),
        .o_valence      (o_valence),
        .o_bucket_start (o_bucket_start),
        .o_face_index   (o_face_index)
    );

    assign o_stall     = !w_cmd.idle;
    assign o_cfg_ready = 1'b1;

endmodule
